// File: rtl/drst_pkg.sv
// shared types, constants and codes for the download rate slice throttle
package drst_pkg;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 22;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THROTTLE_ON = 2'd0,
    CFG_LIMIT_KIB   = 2'd1,
    CFG_SOCK_BUF    = 2'd2
  } cfg_idx_e;

  // field widths
  localparam int KibW    = 22;
  localparam int BufW    = 21;
  localparam int CountW  = 10;
  localparam int BytesW  = 32;
  localparam int PeriodW = 7;

  // arithmetic constants
  localparam int KibShift   = 10;
  localparam int SliceDiv   = 7;
  localparam int PeriodMs   = 1000;
  localparam int CntDivW    = 13;
  localparam int ProdW      = BufW + CountW;
  localparam int ScaledW    = ProdW + 4;
  localparam int KiloW      = 31;
  localparam int DivCntW    = $clog2(BytesW);

  localparam logic [PeriodW-1:0] PERIOD_FULL    = 7'd100;
  localparam logic [BufW-1:0]    SOCK_BUF_RESET = 21'd65536;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_SLICE  = 2'd1,
    MODE_RETURN = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CMP,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CountW-1:0] transfer_count;
    logic [BytesW-1:0] return_bytes;
  } in_item_t;

  typedef struct packed {
    logic [BytesW-1:0]  grant_bytes;
    logic               unlimited;
    logic [BufW-1:0]    slice_bytes;
    logic [PeriodW-1:0] cycle_time_ms;
    logic               throttling;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic cmp;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic tick_go;
    logic div_done;
  } dp_status_t;

endpackage

// File: rtl/drst_div.sv
// iterative restoring divider, one quotient bit per cycle
module drst_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [drst_pkg::BytesW-1:0]  dividend_i,
  input  logic [drst_pkg::BytesW-1:0]  divisor_i,
  output logic                         done_o,
  output logic [drst_pkg::BytesW-1:0]  quotient_o
);
  import drst_pkg::*;

  logic [BytesW-1:0]  rem_q, rem_d;
  logic [BytesW-1:0]  quo_q, quo_d;
  logic [BytesW-1:0]  dvs_q, dvs_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [BytesW:0]    rem_shift;
  logic [BytesW:0]    diff;

  assign rem_shift = {rem_q, quo_q[BytesW-1]};
  assign diff      = rem_shift - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[BytesW]) begin
        rem_d = diff[BytesW-1:0];
        quo_d = {quo_q[BytesW-2:0], 1'b1};
      end else begin
        rem_d = rem_shift[BytesW-1:0];
        quo_d = {quo_q[BytesW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(BytesW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/drst_dp.sv
// datapath: configuration, limiter state, setup arithmetic and result fields
module drst_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [drst_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [drst_pkg::CfgDataW-1:0] cfg_data_i,
  input  drst_pkg::in_item_t            in_item_i,
  input  drst_pkg::dp_cmd_t             cmd_i,
  output drst_pkg::dp_status_t          status_o,
  output drst_pkg::out_item_t           result_o
);
  import drst_pkg::*;

  // configuration registers
  logic            on_q;
  logic [KibW-1:0] kib_q;
  logic [BufW-1:0] buf_q;

  // limiter state
  logic [BytesW-1:0]  limit_q, limit_d;
  logic               en_q, en_d;
  logic [BufW-1:0]    slice_q, slice_d;
  logic [PeriodW-1:0] cycle_q, cycle_d;
  logic [BytesW-1:0]  used_q, used_d;

  // working registers
  in_item_t          in_q;
  logic [ProdW-1:0]  prod_q;
  logic [KiloW-1:0]  kilo_q;
  logic              fast_q;
  logic [BytesW-1:0] grant_q, grant_d;
  logic              unl_q, unl_d;

  logic [BytesW-1:0]  limit_calc;
  logic               en_calc;
  logic [BytesW-1:0]  left;
  logic [BufW:0]      twice;
  logic [ScaledW-1:0] scaled;
  logic               fast_path;
  logic [CntDivW-1:0] cnt7;
  logic [BytesW-1:0]  div_a, div_b;
  logic [BytesW-1:0]  quo;
  logic               div_done;

  assign limit_calc = {kib_q, {KibShift{1'b0}}};
  assign en_calc    = on_q && (kib_q != '0) && (in_q.transfer_count != '0);
  assign left       = (used_q < limit_q) ? (limit_q - used_q) : '0;
  assign twice      = {slice_q, 1'b0};
  // socket buffer * count * 10 as (p << 3) + (p << 1)
  assign scaled     = {1'b0, prod_q, 3'b000} + {3'b000, prod_q, 1'b0};
  assign fast_path  = {{(ScaledW-BytesW){1'b0}}, limit_q} <= scaled;
  assign cnt7       = CntDivW'(in_q.transfer_count) * CntDivW'(SliceDiv);
  assign div_a      = fast_path ? limit_q : BytesW'(kilo_q);
  assign div_b      = fast_path ? BytesW'(cnt7) : limit_q;

  drst_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.cmp),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_comb begin
    limit_d = limit_q;
    en_d    = en_q;
    slice_d = slice_q;
    cycle_d = cycle_q;
    used_d  = used_q;
    grant_d = grant_q;
    unl_d   = unl_q;
    if (cmd_i.exec) begin
      grant_d = '0;
      unl_d   = 1'b0;
      case (in_q.mode)
        MODE_TICK: begin
          limit_d = limit_calc;
          en_d    = en_calc;
          used_d  = '0;
        end
        MODE_SLICE: begin
          if (!en_q) begin
            grant_d = '1;
            unl_d   = 1'b1;
          end else if (left != '0) begin
            grant_d = (left > BytesW'(twice)) ? BytesW'(slice_q) : left;
            used_d  = used_q + grant_d;
          end
        end
        MODE_RETURN: begin
          if ((in_q.return_bytes != '0) && (in_q.return_bytes < BytesW'(twice))) begin
            used_d = (used_q > in_q.return_bytes) ? (used_q - in_q.return_bytes) : '0;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.finish) begin
      if (fast_q) begin
        slice_d = (quo > BytesW'(buf_q)) ? buf_q : quo[BufW-1:0];
        cycle_d = PERIOD_FULL;
      end else begin
        slice_d = buf_q;
        cycle_d = quo[PeriodW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q  <= 1'b0;
      kib_q <= '0;
      buf_q <= SOCK_BUF_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THROTTLE_ON: on_q  <= cfg_data_i[0];
        CFG_LIMIT_KIB:   kib_q <= cfg_data_i[KibW-1:0];
        CFG_SOCK_BUF:    buf_q <= cfg_data_i[BufW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
      en_q    <= 1'b0;
      slice_q <= '0;
      cycle_q <= '0;
      used_q  <= '0;
    end else begin
      limit_q <= limit_d;
      en_q    <= en_d;
      slice_q <= slice_d;
      cycle_q <= cycle_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grant_q <= grant_d;
    unl_q   <= unl_d;
    if (cmd_i.load_in) begin
      in_q <= in_item_i;
    end
    if (cmd_i.exec) begin
      prod_q <= ProdW'(buf_q) * ProdW'(in_q.transfer_count);
      kilo_q <= KiloW'(buf_q) * KiloW'(PeriodMs);
    end
    if (cmd_i.cmp) begin
      fast_q <= fast_path;
    end
  end

  assign status_o.tick_go  = (in_q.mode == MODE_TICK) && en_calc;
  assign status_o.div_done = div_done;

  assign result_o.grant_bytes   = grant_q;
  assign result_o.unlimited     = unl_q;
  assign result_o.slice_bytes   = slice_q;
  assign result_o.cycle_time_ms = cycle_q;
  assign result_o.throttling    = en_q;

endmodule

// File: rtl/drst_ctrl.sv
// controller: sequences accept, execute, setup division and result hand-off
module drst_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  out_free_i,
  output logic                  out_load_o,
  input  drst_pkg::dp_status_t  status_i,
  output drst_pkg::dp_cmd_t     cmd_o
);
  import drst_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.tick_go ? ST_CMP : ST_DONE;
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/download_rate_slice_throttle.sv
// top level of the per-second byte budget rate limiter
//
// usage:
// - input channel (in_valid_i / in_ready_o / in_item_i) carries one
//   transaction per command: second tick, slice request or byte return
// - output channel (out_valid_o / out_ready_i / out_item_o) returns exactly
//   one transaction per input: the grant plus the slice size, cycle period
//   and enable state as they stand after the command
// - config port (cfg_we_i / cfg_idx_i / cfg_data_i) writes throttle enable,
//   limit in KiB/s and socket buffer size; values take effect at the next
//   second tick; write only while no command is in flight
// - requests, returns, the unused mode and ticks that leave throttling off
//   go straight to result hand-off, a tick that enables throttling first
//   runs compare and the 32-step divider; next accept waits for hand-off
// - result goes into an output register, so a new transaction is accepted
//   while the previous result still waits; if the receiver stalls, the
//   block parks the next finished result until the register frees up
// - reset clears the limiter state and disables throttling; the socket
//   buffer size returns to 64 KiB
module download_rate_slice_throttle (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  drst_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output drst_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [drst_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [drst_pkg::CfgDataW-1:0] cfg_data_i
);
  import drst_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  out_item_t  result;
  logic       out_load;
  logic       out_free;

  // output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  // slot is free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_ready_i;

  drst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  drst_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .result_o   (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // controller is busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("accepted a transaction back to back");

  // an unlimited grant is always all ones
  a_unlimited_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.unlimited) |-> (out_item_o.grant_bytes == '1))
    else $error("unlimited grant not all ones");

  // while throttling the period never exceeds the full cycle
  a_period_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.throttling) |-> (out_item_o.cycle_time_ms <= PERIOD_FULL))
    else $error("cycle period out of range");

  // a limited nonzero grant needs throttling enabled
  a_grant_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.unlimited && (out_item_o.grant_bytes != '0))
      |-> out_item_o.throttling)
    else $error("limited grant while throttling is off");

endmodule
